>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the bounded sorted deque list.
// No dependencies; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> hw/rtl/bsdq_pkg.sv
// Package for the bounded sorted deque list: widths, opcodes, status codes,
// cell command and link types. No dependencies.
`timescale 1ns / 1ps

package bsdq_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int DATA_W       = 32;
   localparam int OPCODE_W     = 3;
   localparam int STATUS_W     = 2;
   localparam int COUNT_FLD_W  = 5;

   localparam int REQ_TDATA_W  = 32;
   localparam int REQ_TUSER_W  = 3;
   localparam int RSP_TDATA_W  = 48;

   localparam logic [OPCODE_W-1:0] OP_FRONT    = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_BACK     = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_ORDERED  = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_REMOVE   = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_POP      = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_CONTAINS = 3'd5;

   localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd2;

   localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;

   typedef enum logic [1:0] {
      CELL_IDLE   = 2'd0,
      CELL_SCAN   = 2'd1,
      CELL_INSERT = 2'd2,
      CELL_DELETE = 2'd3
   } cell_op_type;

   // Which cells lie before the insert or delete point.
   typedef enum logic [1:0] {
      BND_NONE   = 2'd0,
      BND_PASSED = 2'd1,
      BND_VALID  = 2'd2
   } bnd_type;

   typedef struct packed {
      cell_op_type              op;
      bnd_type                  bnd;
      logic                     ordered;
      logic signed [DATA_W-1:0] key;
   } cell_cmd_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] entry;
      logic                     valid;
      logic                     passed;
      logic                     tok_pass;
      logic                     head;
   } link_type;

   typedef struct packed {
      logic tok;
      logic stop;
      logic hit;
   } cell_stat_type;

   function automatic logic before_point(bnd_type bnd, logic passed, logic valid);
      logic r;
      unique case (bnd)
         BND_NONE:   r = 1'b0;
         BND_PASSED: r = passed;
         BND_VALID:  r = valid;
         default:    r = 1'b0;
      endcase
      return r;
   endfunction

endpackage

>>> hw/rtl/bounded_sorted_deque_list.sv
// Top level of the bounded sorted deque list: sequencer and row of cells.
// Depends on bsdq_pkg, bsdq_cell and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Ordered list of up to CAPACITY signed 32-bit values held in a row of cells,
// position 0 at the front. Each request is one operation chosen by req_tuser:
// front insert, back insert, ordered insert, remove key, pop front, contains.
// One response follows every request, in order. Front insert, back insert and
// a non-empty pop shift the row in an apply step; a rejected insert, an empty
// pop or an undefined opcode go straight to the response. Ordered insert,
// remove and contains send a search token down the cell row, one cell per
// cycle, until it stops at a position or runs off the end of the list; an
// ordered insert, or a remove that finds its key, then shifts the row too.
// The token walk thus sets how long these operations take.
// A new request is taken while the previous response still waits on rsp_tready.
module bounded_sorted_deque_list #(
   parameter int CAPACITY = bsdq_pkg::CAPACITY_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [bsdq_pkg::REQ_TDATA_W-1:0] req_tdata,  // [31:0] value
   input  logic [bsdq_pkg::REQ_TUSER_W-1:0] req_tuser,  // [2:0] opcode
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [31:0] popped_value, [32] found, [34:33] status, [39:35] entry_count,
   // [40] is_empty, [47:41] zero
   output logic [bsdq_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import bsdq_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_APPLY = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0]               state_ff, state_in;
   logic [OPCODE_W-1:0]      op_ff, op_in;
   logic signed [DATA_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     first_ff, first_in;

   // result being built for the current request
   logic signed [DATA_W-1:0] res_popped_ff, res_popped_in;
   logic                     res_found_ff, res_found_in;
   logic [STATUS_W-1:0]      res_status_ff, res_status_in;

   // response register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_popped_ff, rsp_popped_in;
   logic                     rsp_found_ff, rsp_found_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]         rsp_count_ff, rsp_count_in;

   cell_cmd_type  cmd;
   link_type      link    [CAPACITY];
   cell_stat_type stat    [CAPACITY];
   link_type      head_link, tail_link;

   logic [CAPACITY-1:0] valid_vec, tok_vec, stop_vec, hit_vec;
   logic                any_stop, any_hit, fell_off, accept, is_insert, load_rsp;

   assign accept     = req_tvalid & req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign is_insert  = (op_ff == OP_FRONT) | (op_ff == OP_BACK) | (op_ff == OP_ORDERED);
   assign load_rsp   = (state_ff == ST_DONE) & (!rsp_valid_ff | rsp_tready);

   // Broadcast command to every cell.
   always_comb begin
      cmd.key     = key_ff;
      cmd.ordered = (op_ff == OP_ORDERED);
      unique case (op_ff)
         OP_BACK:    cmd.bnd = BND_VALID;
         OP_ORDERED: cmd.bnd = BND_PASSED;
         OP_REMOVE:  cmd.bnd = BND_PASSED;
         default:    cmd.bnd = BND_NONE;
      endcase
      unique case (state_ff)
         ST_SCAN:  cmd.op = CELL_SCAN;
         ST_APPLY: cmd.op = is_insert ? CELL_INSERT : CELL_DELETE;
         default:  cmd.op = CELL_IDLE;
      endcase
   end

   // Feed the ends of the row: the head injects the token, the tail shifts in
   // an empty slot.
   assign head_link = '{entry: key_ff, valid: 1'b1, passed: 1'b1,
                        tok_pass: first_ff, head: 1'b1};
   assign tail_link = '{entry: '0, valid: 1'b0, passed: 1'b0,
                        tok_pass: 1'b0, head: 1'b0};

   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      link_type left_l, right_l;
      if (k == 0) begin : g_head
         assign left_l = head_link;
      end else begin : g_mid_l
         assign left_l = link[k-1];
      end
      if (k == CAPACITY - 1) begin : g_tail
         assign right_l = tail_link;
      end else begin : g_mid_r
         assign right_l = link[k+1];
      end
      bsdq_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .cmd_i   (cmd),
         .left_i  (left_l),
         .right_i (right_l),
         .link_o  (link[k]),
         .stat_o  (stat[k])
      );
      assign valid_vec[k] = link[k].valid;
      assign tok_vec[k]   = stat[k].tok;
      assign stop_vec[k]  = stat[k].stop;
      assign hit_vec[k]   = stat[k].hit;
   end

   // The token is one-hot, so these reductions flag the single active cell.
   assign any_stop = |stop_vec;
   assign any_hit  = |hit_vec;
   assign fell_off = link[CAPACITY-1].tok_pass;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      count_in      = count_ff;
      first_in      = 1'b0;
      res_popped_in = res_popped_ff;
      res_found_in  = res_found_ff;
      res_status_in = res_status_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in         = req_tuser[OPCODE_W-1:0];
               key_in        = $signed(req_tdata[DATA_W-1:0]);
               res_popped_in = '0;
               res_found_in  = 1'b0;
               res_status_in = STS_OK;
               state_in      = ST_DONE;
               unique case (req_tuser[OPCODE_W-1:0])
                  OP_FRONT, OP_BACK: begin
                     if (count_ff >= CNT_W'(CAPACITY)) begin
                        res_status_in = STS_FULL;
                     end else begin
                        state_in = ST_APPLY;
                     end
                  end
                  OP_ORDERED: begin
                     if (count_ff >= CNT_W'(CAPACITY)) begin
                        res_status_in = STS_FULL;
                     end else begin
                        state_in = ST_SCAN;
                        first_in = 1'b1;
                     end
                  end
                  OP_REMOVE, OP_CONTAINS: begin
                     state_in = ST_SCAN;
                     first_in = 1'b1;
                  end
                  OP_POP: begin
                     if (count_ff == '0) begin
                        res_popped_in = INT_MIN;
                        res_status_in = STS_EMPTY;
                     end else begin
                        // take the front entry before the row shifts
                        res_popped_in = link[0].entry;
                        state_in      = ST_APPLY;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (any_stop | fell_off) begin
               unique case (op_ff)
                  OP_ORDERED: begin
                     state_in = ST_APPLY;
                  end
                  OP_REMOVE: begin
                     res_found_in = any_hit;
                     state_in     = any_hit ? ST_APPLY : ST_DONE;
                  end
                  default: begin
                     res_found_in = any_hit;
                     state_in     = ST_DONE;
                  end
               endcase
            end
         end
         ST_APPLY: begin
            count_in = is_insert ? count_ff + CNT_W'(1) : count_ff - CNT_W'(1);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   // Hold the response until taken; reload it as the next one finishes.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_popped_in = rsp_popped_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      if (load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_popped_in = res_popped_ff;
         rsp_found_in  = res_found_ff;
         rsp_status_in = res_status_ff;
         rsp_count_in  = count_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      res_popped_ff <= res_popped_in;
      res_found_ff  <= res_found_in;
      res_status_ff <= res_status_in;
      rsp_popped_ff <= rsp_popped_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, (rsp_count_ff == '0), COUNT_FLD_W'(rsp_count_ff),
                        rsp_status_ff, rsp_found_ff, rsp_popped_ff};

   // Occupied cells form an unbroken run from the front and match the count.
   `ASSERT_ALWAYS(a_count_matches, clock, reset, $countones(valid_vec) == count_ff, "count mismatch")
   `ASSERT_ALWAYS(a_valid_run, clock, reset, ((valid_vec + 1'b1) & valid_vec) == '0, "gap in list")
   // At most one search token; none outside a search.
   `ASSERT_ALWAYS(a_tok_onehot, clock, reset, $onehot0(tok_vec), "several tokens")
   `ASSERT_IMPLIES(a_tok_idle, clock, reset, state_ff == ST_IDLE, tok_vec == '0, "stale token")

endmodule

>>> hw/rtl/bsdq_cell.sv
// One list position of the bounded sorted deque list: entry, occupancy,
// scan token and shift toward either neighbor. Depends on bsdq_pkg.
`timescale 1ns / 1ps

module bsdq_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  bsdq_pkg::cell_cmd_type cmd_i,
   input  bsdq_pkg::link_type     left_i,
   input  bsdq_pkg::link_type     right_i,
   output bsdq_pkg::link_type     link_o,
   output bsdq_pkg::cell_stat_type stat_o
);
   import bsdq_pkg::*;

   logic signed [DATA_W-1:0] entry_ff, entry_in;
   logic                     valid_ff, valid_in;
   logic                     passed_ff, passed_in;
   logic                     tok_ff, tok_in;

   logic hit_raw, stop, pass_own, ahead, left_ahead, first;

   assign hit_raw    = cmd_i.ordered ? !(entry_ff < cmd_i.key) : (entry_ff == cmd_i.key);
   assign stop       = tok_ff & (!valid_ff | hit_raw);
   assign pass_own   = tok_ff & !stop;
   assign ahead      = before_point(cmd_i.bnd, passed_ff, valid_ff);
   assign left_ahead = before_point(cmd_i.bnd, left_i.passed, left_i.valid);
   assign first      = !ahead & (left_ahead | left_i.head);

   always_comb begin
      entry_in  = entry_ff;
      valid_in  = valid_ff;
      passed_in = passed_ff;
      tok_in    = tok_ff;
      unique case (cmd_i.op)
         CELL_IDLE: begin
            tok_in    = 1'b0;
            passed_in = 1'b0;
         end
         CELL_SCAN: begin
            tok_in    = left_i.tok_pass;
            passed_in = passed_ff | pass_own;
         end
         CELL_INSERT: begin
            tok_in    = 1'b0;
            passed_in = 1'b0;
            if (!ahead) begin
               entry_in = first ? cmd_i.key : left_i.entry;
               valid_in = left_i.valid;
            end
         end
         CELL_DELETE: begin
            tok_in    = 1'b0;
            passed_in = 1'b0;
            if (!ahead) begin
               entry_in = right_i.entry;
               valid_in = right_i.valid;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         valid_ff  <= 1'b0;
         passed_ff <= 1'b0;
         tok_ff    <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         passed_ff <= passed_in;
         tok_ff    <= tok_in;
      end
   end

   assign link_o = '{entry: entry_ff, valid: valid_ff, passed: passed_ff,
                     tok_pass: pass_own, head: 1'b0};
   assign stat_o = '{tok: tok_ff, stop: stop, hit: tok_ff & valid_ff & hit_raw};

endmodule
